@@ rtl/aitd_pkg.sv @@
// shared types and constants for the interleaved address target decoder
// no dependencies
`default_nettype none

package aitd_pkg;

    // defaults for the top level parameters
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF   = 64;

    // fixed field widths
    localparam int ADDR_W   = 64;
    localparam int LINE_W   = 32;
    localparam int CNT_W    = 9;
    localparam int SIDX_W   = 8;
    localparam int SHIFT_W  = 5;
    localparam int TIDX_W   = 4;
    localparam int DEC_W    = 2;
    localparam int INUSE_W  = 5;
    localparam int S_DATA_W = 320;
    localparam int M_DATA_W = 8;

    // shared divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIVD_W = 64;
    localparam int DIVR_W = 32;
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    // command codes (tuser of the input stream)
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // decision codes (tuser of the output stream)
    localparam logic [DEC_W-1:0] DEC_MATCH   = 2'd0;
    localparam logic [DEC_W-1:0] DEC_DEFAULT = 2'd1;
    localparam logic [DEC_W-1:0] DEC_ZERO    = 2'd2;
    localparam logic [DEC_W-1:0] DEC_WRITE   = 2'd3;

    // one table entry
    typedef struct packed {
        logic [ADDR_W-1:0]  rbeg;
        logic [ADDR_W-1:0]  rend;
        logic [63:0]        seed;
        logic [LINE_W-1:0]  line_size;
        logic [CNT_W-1:0]   cnt;
        logic [SIDX_W-1:0]  sidx;
        logic [SHIFT_W-1:0] shift;
        logic               dflt;
        logic               xmode;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/aitd_table.sv @@
// target entry memory: one write port, one read port with registered data
// depends on aitd_pkg
`default_nettype none

module aitd_table #(
    parameter int DEPTH = aitd_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W = 4
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire [IDX_W-1:0]       i_waddr,
    input  aitd_pkg::t_entry      i_wdata,
    input  wire                   i_re,
    input  wire [IDX_W-1:0]       i_raddr,
    output aitd_pkg::t_entry      o_rdata
);

    aitd_pkg::t_entry r_mem [DEPTH];
    aitd_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/aitd_div.sv @@
// restoring divider, one quotient bit per cycle, quotient and remainder
// depends on aitd_pkg
`default_nettype none

module aitd_div (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire [aitd_pkg::DIVD_W-1:0]    i_dividend,
    input  wire [aitd_pkg::DIVR_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [aitd_pkg::DIVD_W-1:0]   o_quot,
    output logic [aitd_pkg::DIVR_W-1:0]   o_rem
);

    logic [aitd_pkg::DIVD_W-1:0] r_q;
    logic [aitd_pkg::DIVR_W-1:0] r_r;
    logic [aitd_pkg::DIVR_W-1:0] r_d;
    logic [aitd_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [aitd_pkg::DIVR_W:0]   trial;
    logic [aitd_pkg::DIVR_W:0]   diff;
    logic                        take;

    // shift in next dividend bit, subtract when it fits
    assign trial = {r_r, r_q[aitd_pkg::DIVD_W-1]};
    assign diff  = trial - {1'b0, r_d};
    assign take  = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= aitd_pkg::DCNT_W'(aitd_pkg::DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == aitd_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[aitd_pkg::DIVD_W-2:0], take};
            r_r <= take ? diff[aitd_pkg::DIVR_W-1:0] : trial[aitd_pkg::DIVR_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

`default_nettype wire

@@ rtl/interleaved_address_target_decoder.sv @@
// interleaved address target decoder: top level, lookup sequencer and output register
// depends on aitd_pkg, aitd_table, aitd_div
//
// channel    dir  handshake              payload
// s_axis     in   tvalid/tready          tuser: cmd; tdata: entry fields
// m_axis     out  tvalid/tready          tuser: decision; tdata: target_index
// cfg        in   i_cfg_we (no wait)     i_cfg_wdata: entries_in_use
//
// a write beat is stored on its accepting edge, then waits in ST_DONE for the output load
// a lookup walks the entries in use, each through ST_CHK (table read) and ST_RNG (range
// test); an interleaved entry in range also waits twice on the shared divider:
// in ST_DIVL (line), then via ST_HASH in ST_MODW (slice modulo); results wait in ST_DONE
// synchronous active-low reset; the table holds no reset, entries_in_use clears
// the output register holds one result, so a stalled m_axis only blocks at the end
`default_nettype none

module interleaved_address_target_decoder #(
    parameter int MAX_ENTRIES = aitd_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = aitd_pkg::ADDR_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_we,
    input  wire [aitd_pkg::INUSE_W-1:0]         i_cfg_wdata,   // entries_in_use
    // input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: addr, entry_index, range_begin, range_end, default flag,
    // slice_count, slice_index, line_size, hash_seed, hash_shift, use_xor_hash, zero pad
    input  wire [aitd_pkg::S_DATA_W-1:0]        s_axis_tdata,
    input  wire                                 s_axis_tuser,  // cmd
    // output stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [aitd_pkg::M_DATA_W-1:0]       m_axis_tdata,  // target_index, zero pad
    output logic [aitd_pkg::DEC_W-1:0]          m_axis_tuser   // decision
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [aitd_pkg::ADDR_W-1:0] ADDR_MASK =
        {aitd_pkg::ADDR_W{1'b1}} >> (aitd_pkg::ADDR_W - ADDR_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_RNG,
        ST_DIVL,
        ST_HASH,
        ST_MODW,
        ST_DONE
    } t_state;

    // input beat fields
    logic [63:0]                     f_addr;
    logic [3:0]                      f_eidx;
    aitd_pkg::t_entry                f_entry;

    assign f_addr            = s_axis_tdata[63:0];
    assign f_eidx            = s_axis_tdata[67:64];
    assign f_entry.rbeg      = s_axis_tdata[131:68] & ADDR_MASK;
    assign f_entry.rend      = s_axis_tdata[195:132] & ADDR_MASK;
    assign f_entry.dflt      = s_axis_tdata[196];
    assign f_entry.cnt       = s_axis_tdata[205:197];
    assign f_entry.sidx      = s_axis_tdata[213:206];
    assign f_entry.line_size = s_axis_tdata[245:214];
    assign f_entry.seed      = s_axis_tdata[309:246];
    assign f_entry.shift     = s_axis_tdata[314:310];
    assign f_entry.xmode     = s_axis_tdata[315];

    t_state                              r_state;
    logic [aitd_pkg::INUSE_W-1:0]        r_inuse;
    logic [ECNT_W-1:0]                   r_e;       // entry under test
    logic [ECNT_W-1:0]                   r_n;       // entries to walk
    logic [ECNT_W-1:0]                   r_dflt;    // last default entry seen
    logic                                r_have_dflt;
    logic [aitd_pkg::ADDR_W-1:0]         r_addr;
    logic [aitd_pkg::TIDX_W-1:0]         r_res_idx;
    logic [aitd_pkg::DEC_W-1:0]          r_res_dec;
    logic                                r_out_valid;
    logic [aitd_pkg::TIDX_W-1:0]         r_out_idx;
    logic [aitd_pkg::DEC_W-1:0]          r_out_dec;

    logic                                s_beat;
    logic                                out_load;
    logic                                tbl_we;
    logic                                tbl_re;
    aitd_pkg::t_entry                    rd;
    logic [ECNT_W-1:0]                   n_walk;

    logic                                in_range;
    logic [aitd_pkg::ADDR_W-1:0]         offset;
    logic [aitd_pkg::DIVR_W-1:0]         line_div;
    logic [aitd_pkg::DIVD_W-1:0]         hashed;
    logic [5:0]                          sh2;

    logic                                div_start;
    logic [aitd_pkg::DIVD_W-1:0]         div_dividend;
    logic [aitd_pkg::DIVR_W-1:0]         div_divisor;
    logic                                div_busy;
    logic                                div_done;
    logic [aitd_pkg::DIVD_W-1:0]         div_quot;
    logic [aitd_pkg::DIVR_W-1:0]         div_rem;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    // result moves into the output register once it is free or being drained
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // entries_in_use above the table depth walks the whole table
    assign n_walk = (r_inuse > MAX_ENTRIES) ? ECNT_W'(MAX_ENTRIES) : ECNT_W'(r_inuse);

    // write beats store at once; an index past the table stores nothing
    assign tbl_we = s_beat && (s_axis_tuser == aitd_pkg::CMD_WRITE) && (f_eidx < MAX_ENTRIES);
    assign tbl_re = (r_state == ST_CHK) && (r_e != r_n);

    aitd_table #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (IDX_W'(f_eidx)),
        .i_wdata (f_entry),
        .i_re    (tbl_re),
        .i_raddr (r_e[IDX_W-1:0]),
        .o_rdata (rd)
    );

    // range test and line offset on the entry just read
    assign in_range = (rd.rbeg <= r_addr) && (r_addr < rd.rend);
    assign offset   = (r_addr - rd.rbeg) & ADDR_MASK;
    assign line_div = (rd.line_size == '0) ? aitd_pkg::DIVR_W'(1) : rd.line_size;

    // slice select: linear keeps the home line, xor mode folds seed and shifted copies
    assign sh2    = {rd.shift, 1'b0};
    assign hashed = rd.xmode ? (div_quot ^ rd.seed ^ (div_quot >> rd.shift) ^ (div_quot >> sh2))
                             : div_quot;

    assign div_start    = ((r_state == ST_RNG) && !rd.dflt && in_range && (rd.cnt > 9'd1))
                       || (r_state == ST_HASH);
    assign div_dividend = (r_state == ST_HASH) ? hashed : offset;
    assign div_divisor  = (r_state == ST_HASH) ? aitd_pkg::DIVR_W'(rd.cnt) : line_div;

    aitd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inuse     <= '0;
            r_out_valid <= 1'b0;
            r_have_dflt <= 1'b0;
            r_e         <= '0;
            r_n         <= '0;
            r_dflt      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_inuse <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_beat) begin
                        if (s_axis_tuser == aitd_pkg::CMD_WRITE) begin
                            r_res_idx <= f_eidx;
                            r_res_dec <= aitd_pkg::DEC_WRITE;
                            r_state   <= ST_DONE;
                        end else begin
                            r_addr      <= f_addr & ADDR_MASK;
                            r_e         <= '0;
                            r_n         <= n_walk;
                            r_have_dflt <= 1'b0;
                            r_state     <= ST_CHK;
                        end
                    end
                end
                ST_CHK: begin
                    if (r_e == r_n) begin
                        // walk finished without a hit
                        if (r_have_dflt) begin
                            r_res_idx <= aitd_pkg::TIDX_W'(r_dflt);
                            r_res_dec <= aitd_pkg::DEC_DEFAULT;
                        end else begin
                            r_res_idx <= '0;
                            r_res_dec <= aitd_pkg::DEC_ZERO;
                        end
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_RNG;
                    end
                end
                ST_RNG: begin
                    if (rd.dflt) begin
                        r_dflt      <= r_e;
                        r_have_dflt <= 1'b1;
                        r_e         <= r_e + 1'b1;
                        r_state     <= ST_CHK;
                    end else if (!in_range) begin
                        r_e     <= r_e + 1'b1;
                        r_state <= ST_CHK;
                    end else if (rd.cnt <= 9'd1) begin
                        r_res_idx <= aitd_pkg::TIDX_W'(r_e);
                        r_res_dec <= aitd_pkg::DEC_MATCH;
                        r_state   <= ST_DONE;
                    end else begin
                        r_state <= ST_DIVL;
                    end
                end
                ST_DIVL: begin
                    if (div_done) begin
                        r_state <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    r_state <= ST_MODW;
                end
                ST_MODW: begin
                    if (div_done) begin
                        if (div_rem == aitd_pkg::DIVR_W'(rd.sidx)) begin
                            r_res_idx <= aitd_pkg::TIDX_W'(r_e);
                            r_res_dec <= aitd_pkg::DEC_MATCH;
                            r_state   <= ST_DONE;
                        end else begin
                            r_e     <= r_e + 1'b1;
                            r_state <= ST_CHK;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out_idx <= r_res_idx;
                        r_out_dec <= r_res_dec;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = aitd_pkg::M_DATA_W'(r_out_idx);
    assign m_axis_tuser  = r_out_dec;

`ifndef SYNTHESIS
    // an entry is only examined while it lies inside the walk
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RNG) |-> (r_e < r_n))
        else $error("entry under test beyond walk length");

    // the shared divider is never restarted mid-operation
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // divider completion is only awaited in its wait states
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == ST_DIVL) || (r_state == ST_MODW)))
        else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire
